// File: hdl/ccf_pkg.sv
// ----------------------------------------------------------------------------
// ccf_pkg
// Shared types, codes and helpers for the camera command framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ccf_pkg;

    // Item kind codes
    localparam logic KIND_REQUEST    = 1'b0;
    localparam logic KIND_REPLY_BYTE = 1'b1;

    // Frame header length in bytes (length, sequence, command)
    localparam logic [2:0] HEADER_LEN = 3'd3;

    // One captured input request
    typedef struct packed {
        logic        kind;
        logic [7:0]  command_code;
        logic [31:0] argument;
        logic [1:0]  arg_size_code;
        logic [1:0]  reply_size_code;
        logic [7:0]  rx_byte;
    } ccf_item_t;

    // One frame byte from the framer
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } ccf_tx_beat_t;

    // Reply completion from the collector
    typedef struct packed {
        logic        valid;
        logic [31:0] value;
    } ccf_reply_t;

    // Size code to byte count: none, one, two, four
    function automatic logic [2:0] size_bytes(input logic [1:0] code);
        logic [2:0] n;
        unique case (code)
            2'd0:    n = 3'd0;
            2'd1:    n = 3'd1;
            2'd2:    n = 3'd2;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// File: hdl/camera_command_framer.sv
// ----------------------------------------------------------------------------
// camera_command_framer
// Top level: input request register, framer, reply collector, result register.
// ----------------------------------------------------------------------------
// Flow: an accepted request is loaded into the request register, and its first
// result passes from there into the result register.
// Throughput: a command request yields 3, 4, 5 or 7 frame bytes, one frame byte
// per cycle through the result register while the output is not stalled; a
// received byte gives a result only when it completes a reply.
// The next request is accepted while the final result waits on the output.
// Reset: sequence number returns to 1, no reply is pending, output is empty.
`timescale 1ns / 1ps
`default_nettype none

module camera_command_framer
(
    input  wire         clk,
    input  wire         rst_n,

    input  wire         in_valid,
    output logic        in_stall,
    input  wire         kind,
    input  wire  [7:0]  command_code,
    input  wire  [31:0] argument,
    input  wire  [1:0]  arg_size_code,
    input  wire  [1:0]  reply_size_code,
    input  wire  [7:0]  rx_byte,

    output logic        out_valid,
    input  wire         out_stall,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        tx_last,
    output logic        reply_valid,
    output logic [31:0] reply_value
);

    logic               work_valid_reg;
    logic               work_valid_next;
    ccf_pkg::ccf_item_t work_item_reg;

    logic               out_valid_reg;
    logic               out_valid_next;

    logic               in_accept;
    logic               adv;
    logic               is_req;
    logic               done;
    logic               emit;

    ccf_pkg::ccf_tx_beat_t beat;
    ccf_pkg::ccf_reply_t   reply;

    // Handshake and advance control
    assign is_req    = (work_item_reg.kind == ccf_pkg::KIND_REQUEST);
    assign adv       = work_valid_reg && (!out_valid_reg || !out_stall);
    assign done      = adv && (!is_req || beat.last);
    assign in_stall  = work_valid_reg && !done;
    assign in_accept = in_valid && !in_stall;
    assign emit      = adv && (is_req || reply.valid);

    // Frame byte generator
    ccf_framer u_framer
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (adv && is_req),
        .item  (work_item_reg),
        .beat  (beat)
    );

    // Reply tracking
    ccf_collector u_collector
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .arm             (adv && is_req && beat.last),
        .reply_size_code (work_item_reg.reply_size_code),
        .rx_step         (adv && !is_req),
        .rx_byte         (work_item_reg.rx_byte),
        .reply           (reply)
    );

    // Request register
    assign work_valid_next = in_accept ? 1'b1 : (done ? 1'b0 : work_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            work_item_reg.kind            <= kind;
            work_item_reg.command_code    <= command_code;
            work_item_reg.argument        <= argument;
            work_item_reg.arg_size_code   <= arg_size_code;
            work_item_reg.reply_size_code <= reply_size_code;
            work_item_reg.rx_byte         <= rx_byte;
        end
    end

    // Result register
    assign out_valid_next = emit ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            tx_valid    <= is_req;
            tx_byte     <= is_req ? beat.data : 8'd0;
            tx_last     <= is_req && beat.last;
            reply_valid <= !is_req;
            reply_value <= is_req ? 32'd0 : reply.value;
        end
    end

    assign out_valid = out_valid_reg;

    // Checks
    a_result_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tx_valid != reply_valid))
        else $error("result carries both a frame byte and a reply");

    a_last_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tx_last) |-> tx_valid)
        else $error("frame end mark without a frame byte");

    a_reply_from_rx: assert property (@(posedge clk) disable iff (!rst_n)
        reply.valid |-> (work_valid_reg && !is_req))
        else $error("reply completed without a received byte");

    a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && is_req && !beat.last) |=> (work_valid_reg && is_req))
        else $error("request dropped before its last frame byte");

endmodule

`default_nettype wire

// File: hdl/ccf_framer.sv
// ----------------------------------------------------------------------------
// ccf_framer
// Walks one command request out as frame bytes and owns the sequence number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccf_framer
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 step,
    input  wire ccf_pkg::ccf_item_t item,
    output ccf_pkg::ccf_tx_beat_t beat
);

    logic [7:0] seq_reg;
    logic [7:0] seq_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;

    logic [2:0] frame_len;
    logic [2:0] arg_off;

    // Frame length and argument byte offset
    assign frame_len = ccf_pkg::HEADER_LEN + ccf_pkg::size_bytes(item.arg_size_code);
    assign arg_off   = idx_reg - ccf_pkg::HEADER_LEN;

    // Byte select for the current position
    always_comb
    begin
        unique case (idx_reg)
            3'd0:    beat.data = {5'd0, frame_len};
            3'd1:    beat.data = seq_reg;
            3'd2:    beat.data = item.command_code;
            default: beat.data = item.argument[{arg_off[1:0], 3'b000} +: 8];
        endcase
        beat.last = (idx_reg == (frame_len - 3'd1));
    end

    // Position and sequence advance
    always_comb
    begin
        idx_next = idx_reg;
        seq_next = seq_reg;
        if (step)
        begin
            if (beat.last)
            begin
                idx_next = 3'd0;
                seq_next = seq_reg + 8'd1;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= 8'd1;
            idx_reg <= 3'd0;
        end
        else
        begin
            seq_reg <= seq_next;
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ccf_collector.sv
// ----------------------------------------------------------------------------
// ccf_collector
// Counts received bytes against the armed reply and assembles the reply value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccf_collector
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                arm,
    input  wire  [1:0]         reply_size_code,
    input  wire                rx_step,
    input  wire  [7:0]         rx_byte,
    output ccf_pkg::ccf_reply_t reply
);

    logic        pending_reg;
    logic        pending_next;
    logic [2:0]  exp_len_reg;
    logic [2:0]  exp_len_next;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;

    logic [2:0]  pay_off;
    logic [31:0] acc_upd;
    logic        final_byte;

    assign pay_off = count_reg - ccf_pkg::HEADER_LEN;

    // Accumulator update for the incoming byte
    always_comb
    begin
        acc_upd = acc_reg;
        if (exp_len_reg == ccf_pkg::HEADER_LEN)
        begin
            // status-only reply: third byte is the value
            if (count_reg == 3'd2)
            begin
                acc_upd = {24'd0, rx_byte};
            end
        end
        else if (count_reg >= ccf_pkg::HEADER_LEN)
        begin
            acc_upd = acc_reg | ({24'd0, rx_byte} << {pay_off[1:0], 3'b000});
        end
    end

    assign final_byte  = ({1'b0, count_reg} + 4'd1) >= {1'b0, exp_len_reg};
    assign reply.valid = rx_step && pending_reg && final_byte;
    assign reply.value = acc_upd;

    // Reply state update
    always_comb
    begin
        pending_next = pending_reg;
        exp_len_next = exp_len_reg;
        count_next   = count_reg;
        acc_next     = acc_reg;
        if (arm)
        begin
            pending_next = 1'b1;
            exp_len_next = ccf_pkg::HEADER_LEN + ccf_pkg::size_bytes(reply_size_code);
            count_next   = 3'd0;
            acc_next     = 32'd0;
        end
        else if (rx_step && pending_reg)
        begin
            acc_next = acc_upd;
            if (final_byte)
            begin
                pending_next = 1'b0;
                count_next   = 3'd0;
            end
            else
            begin
                count_next = count_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            exp_len_reg <= 3'd0;
            count_reg   <= 3'd0;
            acc_reg     <= 32'd0;
        end
        else
        begin
            pending_reg <= pending_next;
            exp_len_reg <= exp_len_next;
            count_reg   <= count_next;
            acc_reg     <= acc_next;
        end
    end

endmodule

`default_nettype wire

// File: bench/camera_command_framer_test.sv
// ----------------------------------------------------------------------------
// camera_command_framer_test
// Drives command and reply-byte requests into the camera command framer with
// random gaps and output stalls. A scoreboard keeps its own copy of the
// sequence number and reply counters, predicts every frame byte and reply,
// and compares each accepted output field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module camera_command_framer_test;

    localparam int RANDOM_ITEMS   = 310;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int IDLE_PERCENT   = 24;
    localparam int PRINT_CAP      = 30;

    // One output beat: a frame byte or a completed reply
    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic        reply_valid;
        logic [31:0] reply_value;
    } framer_result_t;

    // Predicts frame bytes and replies and holds them until they come out
    class framer_scoreboard;
        framer_result_t expected_q[$];
        int             errors;
        logic [7:0]     seq_num;
        logic           reply_armed;
        logic [2:0]     reply_len;
        logic [2:0]     bytes_seen;
        logic [31:0]    reply_acc;

        function new();
            errors      = 0;
            seq_num     = 8'd1;
            reply_armed = 1'b0;
            reply_len   = 3'd0;
            bytes_seen  = 3'd0;
            reply_acc   = 32'd0;
        endfunction

        static function logic [2:0] payload_bytes(input logic [1:0] code);
            return (code == 2'd3) ? 3'd4 : {1'b0, code};
        endfunction

        // Note an accepted request and queue the results it causes
        function void note_item(input ccf_pkg::ccf_item_t it);
            framer_result_t r;
            logic [2:0]     frame_len;
            logic [3:0]     next_count;
            logic [7:0]     fb;
            if (it.kind == ccf_pkg::KIND_REQUEST) begin
                frame_len = ccf_pkg::HEADER_LEN + payload_bytes(it.arg_size_code);
                for (int i = 0; i < 7; i++) begin
                    if (i < frame_len) begin
                        case (i)
                            0:       fb = {5'd0, frame_len};
                            1:       fb = seq_num;
                            2:       fb = it.command_code;
                            default: fb = it.argument[8*(i-3) +: 8];
                        endcase
                        r = '0;
                        r.tx_valid = 1'b1;
                        r.tx_byte  = fb;
                        r.tx_last  = (i == frame_len - 1);
                        expected_q.push_back(r);
                    end
                end
                seq_num     = seq_num + 8'd1;
                reply_armed = 1'b1;
                reply_len   = ccf_pkg::HEADER_LEN + payload_bytes(it.reply_size_code);
                bytes_seen  = 3'd0;
                reply_acc   = 32'd0;
            end else if (reply_armed) begin
                // status-only reply keeps the third byte; others build LSB first
                if (reply_len == ccf_pkg::HEADER_LEN) begin
                    if (bytes_seen == 3'd2)
                        reply_acc = {24'd0, it.rx_byte};
                end else if (bytes_seen >= 3'd3 && bytes_seen < 3'd7) begin
                    reply_acc = reply_acc | ({24'd0, it.rx_byte} << (8 * (bytes_seen - 3'd3)));
                end
                next_count = {1'b0, bytes_seen} + 4'd1;
                bytes_seen = next_count[2:0];
                if (next_count >= {1'b0, reply_len}) begin
                    r = '0;
                    r.reply_valid = 1'b1;
                    r.reply_value = reply_acc;
                    expected_q.push_back(r);
                    reply_armed = 1'b0;
                    bytes_seen  = 3'd0;
                end
            end
        endfunction

        task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
            if (errors < PRINT_CAP)
                $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
            errors++;
        endtask

        // Compare one accepted output with the oldest expectation
        task check_result(input framer_result_t got);
            framer_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, tx_byte/reply_value", 
                                got.tx_valid ? {24'd0, got.tx_byte} : got.reply_value, 32'd0);
            end else begin
                want = expected_q.pop_front();
                if (got.tx_valid !== want.tx_valid)
                    report_mismatch("tx_valid", {31'd0, got.tx_valid}, {31'd0, want.tx_valid});
                if (got.tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", {24'd0, got.tx_byte}, {24'd0, want.tx_byte});
                if (got.tx_last !== want.tx_last)
                    report_mismatch("tx_last", {31'd0, got.tx_last}, {31'd0, want.tx_last});
                if (got.reply_valid !== want.reply_valid)
                    report_mismatch("reply_valid", {31'd0, got.reply_valid},
                                    {31'd0, want.reply_valid});
                if (got.reply_value !== want.reply_value)
                    report_mismatch("reply_value", got.reply_value, want.reply_value);
            end
        endtask
    endclass

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        in_valid        = 1'b0;
    logic        in_stall;
    logic        kind            = 1'b0;
    logic [7:0]  command_code    = 8'd0;
    logic [31:0] argument        = 32'd0;
    logic [1:0]  arg_size_code   = 2'd0;
    logic [1:0]  reply_size_code = 2'd0;
    logic [7:0]  rx_byte         = 8'd0;
    logic        out_valid;
    logic        out_stall       = 1'b0;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        reply_valid;
    logic [31:0] reply_value;

    framer_scoreboard sb = new();
    logic quiet         = 1'b0;
    int   items_counted = 0;
    int   idle_cycles   = 0;

    camera_command_framer DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .command_code    (command_code),
        .argument        (argument),
        .arg_size_code   (arg_size_code),
        .reply_size_code (reply_size_code),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .tx_valid        (tx_valid),
        .tx_byte         (tx_byte),
        .tx_last         (tx_last),
        .reply_valid     (reply_valid),
        .reply_value     (reply_value)
    );

    always #5 clk = ~clk;

    // Output side: random stall, check every accepted result
    always @(posedge clk) begin
        framer_result_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.tx_valid    = tx_valid;
            got.tx_byte     = tx_byte;
            got.tx_last     = tx_last;
            got.reply_valid = reply_valid;
            got.reply_value = reply_value;
            sb.check_result(got);
        end
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
    end

    // Watchdog: too long with no request moving on either side
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Present one request, with a random gap first, and wait for acceptance
    task automatic send_item(input logic k, input logic [7:0] cmd, input logic [31:0] arg,
                             input logic [1:0] asz, input logic [1:0] rsz,
                             input logic [7:0] rxb);
        ccf_pkg::ccf_item_t it;
        it.kind            = k;
        it.command_code    = cmd;
        it.argument        = arg;
        it.arg_size_code   = asz;
        it.reply_size_code = rsz;
        it.rx_byte         = rxb;
        if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            do begin
                @(posedge clk);
            end while ($urandom_range(99) < IDLE_PERCENT);
        end
        in_valid        <= 1'b1;
        kind            <= k;
        command_code    <= cmd;
        argument        <= arg;
        arg_size_code   <= asz;
        reply_size_code <= rsz;
        rx_byte         <= rxb;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_counted++;
        sb.note_item(it);
    endtask

    task automatic send_command(input logic [1:0] asz, input logic [1:0] rsz);
        send_item(ccf_pkg::KIND_REQUEST, 8'($urandom), $urandom, asz, rsz, 8'($urandom));
    endtask

    task automatic send_rx_bytes(input int n);
        for (int i = 0; i < n; i++)
            send_item(ccf_pkg::KIND_REPLY_BYTE, 8'($urandom), $urandom,
                      2'($urandom), 2'($urandom), 8'($urandom));
    endtask

    initial begin
        int         choice;
        int         reply_bytes;
        logic [1:0] asz;
        logic [1:0] rsz;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: stray byte with nothing pending is dropped
        send_item(ccf_pkg::KIND_REPLY_BYTE, 8'hFF, 32'hFFFF_FFFF, 2'd3, 2'd3, 8'hFF);
        // smallest frame, status-only reply
        send_item(ccf_pkg::KIND_REQUEST, 8'h00, 32'h0000_0000, 2'd0, 2'd0, 8'hFF);
        send_item(ccf_pkg::KIND_REPLY_BYTE, 8'h00, 32'h0, 2'd0, 2'd0, 8'h00);
        send_item(ccf_pkg::KIND_REPLY_BYTE, 8'h00, 32'h0, 2'd0, 2'd0, 8'h00);
        send_item(ccf_pkg::KIND_REPLY_BYTE, 8'h00, 32'h0, 2'd0, 2'd0, 8'hA5);
        // largest frame, four-byte reply
        send_item(ccf_pkg::KIND_REQUEST, 8'hFF, 32'hFFFF_FFFF, 2'd3, 2'd3, 8'h00);
        send_item(ccf_pkg::KIND_REPLY_BYTE, 8'hFF, 32'hFFFF_FFFF, 2'd3, 2'd3, 8'h07);
        send_item(ccf_pkg::KIND_REPLY_BYTE, 8'hFF, 32'hFFFF_FFFF, 2'd3, 2'd3, 8'h5A);
        send_item(ccf_pkg::KIND_REPLY_BYTE, 8'hFF, 32'hFFFF_FFFF, 2'd3, 2'd3, 8'h3C);
        send_item(ccf_pkg::KIND_REPLY_BYTE, 8'h00, 32'h0, 2'd0, 2'd0, 8'hFF);
        send_item(ccf_pkg::KIND_REPLY_BYTE, 8'h00, 32'h0, 2'd0, 2'd0, 8'h01);
        send_item(ccf_pkg::KIND_REPLY_BYTE, 8'h00, 32'h0, 2'd0, 2'd0, 8'h80);
        send_item(ccf_pkg::KIND_REPLY_BYTE, 8'h00, 32'h0, 2'd0, 2'd0, 8'hC3);
        // one-byte argument; reply cut short by a new request
        send_item(ccf_pkg::KIND_REQUEST, 8'h81, 32'h1234_56F0, 2'd1, 2'd1, 8'h00);
        send_item(ccf_pkg::KIND_REPLY_BYTE, 8'h00, 32'h0, 2'd0, 2'd0, 8'h11);
        send_item(ccf_pkg::KIND_REPLY_BYTE, 8'h00, 32'h0, 2'd0, 2'd0, 8'h22);
        // two-byte argument and two-byte reply
        send_item(ccf_pkg::KIND_REQUEST, 8'h7E, 32'h8000_ABCD, 2'd2, 2'd2, 8'h55);
        send_rx_bytes(5);
        // surplus byte after the reply completed is dropped
        send_item(ccf_pkg::KIND_REPLY_BYTE, 8'h00, 32'h0, 2'd0, 2'd0, 8'h99);

        // Random: mostly complete command/reply exchanges
        while (items_counted < RANDOM_ITEMS) begin
            quiet = (items_counted >= 150 && items_counted < 210);
            choice      = $urandom_range(99);
            asz         = 2'($urandom);
            rsz         = 2'($urandom);
            reply_bytes = 3 + framer_scoreboard::payload_bytes(rsz);
            if (choice < 50) begin
                send_command(asz, rsz);
                send_rx_bytes(reply_bytes);
            end else if (choice < 80) begin
                send_command(asz, rsz);
            end else if (choice < 90) begin
                send_command(asz, rsz);
                send_rx_bytes($urandom_range(1, reply_bytes - 1));
            end else begin
                send_rx_bytes($urandom_range(1, 3));
            end
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        // Drain outstanding results, then watch for stray ones
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
